@@ rtl/vts_pkg.sv @@
// Shared types, widths and helpers of the trilinear volume sampler.
// No dependencies; vts_front, vts_back and the top level import this package.
package vts_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned COORD_W  = 13;
  localparam int unsigned SIZE_W   = 6;
  localparam int unsigned INDEX_W  = 15;

  // Derived internal widths. An axis position may reach size minus one plus one.
  localparam int unsigned AXIS_W  = COORD_W - FRAC_W + 1;
  localparam int unsigned PLANE_W = 2 * SIZE_W;
  localparam int unsigned YOFF_W  = AXIS_W + SIZE_W;
  localparam int unsigned ZOFF_W  = AXIS_W + PLANE_W;
  localparam int unsigned SUM_W   = ZOFF_W + 1;
  localparam int unsigned LIMIT_W = SIZE_W + FRAC_W;
  localparam int unsigned DIFF_W  = SAMPLE_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int unsigned SH_W    = PROD_W - FRAC_W;

  // Default volume bounds and register reset value.
  localparam int unsigned MAX_DIM_X_DEF = 32;
  localparam int unsigned MAX_DIM_Y_DEF = 32;
  localparam int unsigned MAX_DIM_Z_DEF = 32;
  localparam int unsigned SIZE_RESET    = 32;

  // Queue depths between the parts.
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_X_SIZE = 2'd0;
  localparam logic [1:0] REG_Y_SIZE = 2'd1;
  localparam logic [1:0] REG_Z_SIZE = 2'd2;

  // Request type codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // What the back part has to do with one command.
  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_WRITE,
    KIND_QUERY
  } kind_e;

  typedef struct packed {
    logic                       req_type;
    logic [INDEX_W-1:0]         voxel_index;
    logic signed [SAMPLE_W-1:0] voxel_value;
    logic [COORD_W-1:0]         coord_x;
    logic [COORD_W-1:0]         coord_y;
    logic [COORD_W-1:0]         coord_z;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_of_bounds;
  } res_t;

  typedef struct packed {
    kind_e                      kind;
    logic                       oob;
    logic [INDEX_W-1:0]         wr_index;
    logic signed [SAMPLE_W-1:0] wr_value;
    logic [AXIS_W-1:0]          x0;
    logic [AXIS_W-1:0]          x1;
    logic [YOFF_W-1:0]          yoff0;
    logic [YOFF_W-1:0]          yoff1;
    logic [ZOFF_W-1:0]          zoff0;
    logic [ZOFF_W-1:0]          zoff1;
    logic [FRAC_W-1:0]          fx;
    logic [FRAC_W-1:0]          fy;
    logic [FRAC_W-1:0]          fz;
  } cmd_t;

  // A size of zero acts as one, and a size above the bound saturates.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxdim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (32'(v) > maxdim) begin
      r = SIZE_W'(maxdim);
    end
    return r;
  endfunction

endpackage

@@ rtl/vts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module vts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/vts_fifo.sv @@
// Small register-based queue that carries any packed type.
// No dependencies.
module vts_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  // Pointer and fill-level update with wrap at the depth.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/vts_front.sv @@
// Front part: accepts request beats, classifies them and precomputes corner offsets.
// Depends on vts_pkg and vts_fifo (the command queue toward the back part).
module vts_front import vts_pkg::*; #(
  parameter int unsigned STORE_DEPTH = MAX_DIM_X_DEF * MAX_DIM_Y_DEF * MAX_DIM_Z_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  req_t               req_i,
  output logic               full_o,
  input  logic [SIZE_W-1:0]  x_size_i,
  input  logic [SIZE_W-1:0]  y_size_i,
  input  logic [SIZE_W-1:0]  z_size_i,
  input  logic [PLANE_W-1:0] plane_i,
  input  logic               cmd_pop_i,
  output cmd_t               cmd_o,
  output logic               cmd_empty_o
);

  logic [SIZE_W-1:0]  xm1, ym1, zm1;
  logic [AXIS_W-1:0]  px, py, pz, nx, ny, nz;
  logic               oob;
  cmd_t               cmd;

  assign xm1 = x_size_i - 1'b1;
  assign ym1 = y_size_i - 1'b1;
  assign zm1 = z_size_i - 1'b1;

  // Integer parts of the coordinates.
  assign px = AXIS_W'(req_i.coord_x[COORD_W-1:FRAC_W]);
  assign py = AXIS_W'(req_i.coord_y[COORD_W-1:FRAC_W]);
  assign pz = AXIS_W'(req_i.coord_z[COORD_W-1:FRAC_W]);

  // Neighbor planes; the last plane of an axis uses itself.
  assign nx = (SIZE_W'(px) < xm1) ? px + 1'b1 : px;
  assign ny = (SIZE_W'(py) < ym1) ? py + 1'b1 : py;
  assign nz = (SIZE_W'(pz) < zm1) ? pz + 1'b1 : pz;

  // A coordinate beyond size minus one in any axis flags the query.
  assign oob = (LIMIT_W'(req_i.coord_x) > {xm1, {FRAC_W{1'b0}}}) ||
               (LIMIT_W'(req_i.coord_y) > {ym1, {FRAC_W{1'b0}}}) ||
               (LIMIT_W'(req_i.coord_z) > {zm1, {FRAC_W{1'b0}}});

  // Build the command for the back part.
  always_comb begin
    cmd          = '0;
    cmd.kind     = KIND_NOP;
    cmd.wr_index = req_i.voxel_index;
    cmd.wr_value = req_i.voxel_value;
    cmd.x0       = px;
    cmd.x1       = nx;
    cmd.yoff0    = YOFF_W'(py) * YOFF_W'(x_size_i);
    cmd.yoff1    = YOFF_W'(ny) * YOFF_W'(x_size_i);
    cmd.zoff0    = ZOFF_W'(pz) * ZOFF_W'(plane_i);
    cmd.zoff1    = ZOFF_W'(nz) * ZOFF_W'(plane_i);
    cmd.fx       = req_i.coord_x[FRAC_W-1:0];
    cmd.fy       = req_i.coord_y[FRAC_W-1:0];
    cmd.fz       = req_i.coord_z[FRAC_W-1:0];
    if (req_i.req_type == REQ_WRITE) begin
      // A write beyond the store is dropped but still answered.
      if (32'(req_i.voxel_index) < STORE_DEPTH) begin
        cmd.kind = KIND_WRITE;
      end
    end else if (oob) begin
      cmd.oob = 1'b1;
    end else begin
      cmd.kind = KIND_QUERY;
    end
  end

  vts_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

@@ rtl/vts_back.sv @@
// Back part: voxel store, eight-corner read sequencer, shared lerp unit, result queue.
// Depends on vts_pkg, vts_ram and vts_fifo.
module vts_back import vts_pkg::*; #(
  parameter int unsigned STORE_DEPTH = MAX_DIM_X_DEF * MAX_DIM_Y_DEF * MAX_DIM_Z_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output res_t res_o,
  output logic empty_o
);

  localparam int unsigned ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [3:0] STEP_LAST = 4'd13;

  logic                       state_q, state_d;
  logic [3:0]                 step_q, step_d;
  cmd_t                       cur_q;
  logic                       start;
  logic                       res_full, res_push;
  res_t                       res_data;

  logic [ADDR_W-1:0]          raddr, waddr;
  logic [SAMPLE_W-1:0]        rdata_raw;
  logic signed [SAMPLE_W-1:0] rdata;
  logic [AXIS_W-1:0]          cx;
  logic [YOFF_W-1:0]          cy;
  logic [ZOFF_W-1:0]          cz;

  logic signed [SAMPLE_W-1:0] va_q;
  logic signed [SAMPLE_W-1:0] part_q [6];
  logic signed [SAMPLE_W-1:0] mul_a, mul_b;
  logic [FRAC_W-1:0]          mul_f;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_W-1:0] lerp_a_q;
  logic signed [SH_W-1:0]     lerp_sum;
  logic signed [SAMPLE_W-1:0] lerp_y;

  // Take a command when idle and the result queue has room for its answer.
  assign start     = (state_q == ST_IDLE) && !cmd_empty_i && !res_full;
  assign cmd_pop_o = start;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (start && (cmd_i.kind == KIND_QUERY)) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= cmd_i;
    end
  end

  // Corner k of the query: x from bit 1, y from bit 2, z from bit 0.
  assign cx    = step_q[1] ? cur_q.x1 : cur_q.x0;
  assign cy    = step_q[2] ? cur_q.yoff1 : cur_q.yoff0;
  assign cz    = step_q[0] ? cur_q.zoff1 : cur_q.zoff0;
  assign raddr = ADDR_W'(SUM_W'(cx) + SUM_W'(cy) + SUM_W'(cz));
  assign waddr = ADDR_W'(cmd_i.wr_index);

  vts_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (start && (cmd_i.kind == KIND_WRITE)),
    .waddr_i (waddr),
    .wdata_i (cmd_i.wr_value),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = $signed(rdata_raw);

  // Operand selection for the shared lerp multiplier.
  always_comb begin
    mul_a = va_q;
    mul_b = rdata;
    mul_f = cur_q.fz;
    case (step_q)
      4'd9: begin
        mul_a = part_q[0];
        mul_b = part_q[1];
        mul_f = cur_q.fx;
      end
      4'd10: begin
        mul_a = part_q[2];
        mul_b = part_q[3];
        mul_f = cur_q.fx;
      end
      4'd12: begin
        mul_a = part_q[4];
        mul_b = part_q[5];
        mul_f = cur_q.fy;
      end
      default: begin
        mul_a = va_q;
        mul_b = rdata;
        mul_f = cur_q.fz;
      end
    endcase
  end

  // First half of a lerp: difference times fraction, registered.
  assign diff = DIFF_W'(mul_b) - DIFF_W'(mul_a);

  always_ff @(posedge clk_i) begin
    prod_q   <= diff * $signed({1'b0, mul_f});
    lerp_a_q <= mul_a;
  end

  // Second half: add the floored, scaled product to the start value.
  assign lerp_sum = SH_W'(lerp_a_q) + prod_q[PROD_W-1:FRAC_W];
  assign lerp_y   = lerp_sum[SAMPLE_W-1:0];

  // Capture first corners of each pair and the partial lerp results.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      case (step_q)
        4'd1: va_q <= rdata;
        4'd3: begin
          va_q      <= rdata;
          part_q[0] <= lerp_y;
        end
        4'd5: begin
          va_q      <= rdata;
          part_q[1] <= lerp_y;
        end
        4'd7: begin
          va_q      <= rdata;
          part_q[2] <= lerp_y;
        end
        4'd9:  part_q[3] <= lerp_y;
        4'd10: part_q[4] <= lerp_y;
        4'd11: part_q[5] <= lerp_y;
        default: begin
        end
      endcase
    end
  end

  // Writes and flagged queries answer at once; a query at its last step.
  assign res_push = (start && (cmd_i.kind != KIND_QUERY)) ||
                    ((state_q == ST_RUN) && (step_q == STEP_LAST));

  always_comb begin
    res_data = '0;
    if (state_q == ST_RUN) begin
      res_data.sample_out = lerp_y;
    end else begin
      res_data.out_of_bounds = cmd_i.oob;
    end
  end

  vts_fifo #(
    .T     (res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

endmodule

@@ rtl/volume_trilinear_sampler_unit.sv @@
// Top level of the trilinear volume sampler: size registers and part wiring.
// Depends on vts_pkg, vts_front and vts_back.
//
//   channel  direction  handshake              payload
//   req      in         push / full            req_i (req_t)
//   res      out        empty / pop            res_o (res_t)
//   cfg      in         psel/penable/pready    paddr, pwdata, prdata
//
// A voxel write or a flagged query is answered as the back part takes it; a good
// query is issued, then makes eight reads from the single store read port, then
// runs the lerp chain through one shared multiplier.
// Reset sets all sizes to 32 (clamped to the bounds); the store is not cleared.
// Two command and two result entries let requests queue while results wait.
module volume_trilinear_sampler_unit import vts_pkg::*; #(
  parameter int unsigned MAX_DIM_X = MAX_DIM_X_DEF,
  parameter int unsigned MAX_DIM_Y = MAX_DIM_Y_DEF,
  parameter int unsigned MAX_DIM_Z = MAX_DIM_Z_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  req_t               req_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output res_t               res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned STORE_DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
  localparam logic [SIZE_W-1:0] XS_RST = clamp_size(SIZE_W'(SIZE_RESET), MAX_DIM_X);
  localparam logic [SIZE_W-1:0] YS_RST = clamp_size(SIZE_W'(SIZE_RESET), MAX_DIM_Y);
  localparam logic [SIZE_W-1:0] ZS_RST = clamp_size(SIZE_W'(SIZE_RESET), MAX_DIM_Z);
  localparam logic [PLANE_W-1:0] PLANE_RST = PLANE_W'(XS_RST) * PLANE_W'(YS_RST);

  logic [SIZE_W-1:0]  x_size_q, x_size_d;
  logic [SIZE_W-1:0]  y_size_q, y_size_d;
  logic [SIZE_W-1:0]  z_size_q, z_size_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic               cfg_we;
  logic [SIZE_W-1:0]  wsize;
  cmd_t               cmd;
  logic               cmd_empty, cmd_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign wsize  = pwdata[SIZE_W-1:0];

  // Size register writes; the plane size follows the x and y sizes.
  always_comb begin
    x_size_d = x_size_q;
    y_size_d = y_size_q;
    z_size_d = z_size_q;
    plane_d  = plane_q;
    if (cfg_we) begin
      case (paddr[3:2])
        REG_X_SIZE: begin
          x_size_d = clamp_size(wsize, MAX_DIM_X);
          plane_d  = PLANE_W'(x_size_d) * PLANE_W'(y_size_q);
        end
        REG_Y_SIZE: begin
          y_size_d = clamp_size(wsize, MAX_DIM_Y);
          plane_d  = PLANE_W'(x_size_q) * PLANE_W'(y_size_d);
        end
        REG_Z_SIZE: begin
          z_size_d = clamp_size(wsize, MAX_DIM_Z);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_size_q <= XS_RST;
      y_size_q <= YS_RST;
      z_size_q <= ZS_RST;
      plane_q  <= PLANE_RST;
    end else begin
      x_size_q <= x_size_d;
      y_size_q <= y_size_d;
      z_size_q <= z_size_d;
      plane_q  <= plane_d;
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_X_SIZE: prdata = PDATA_W'(x_size_q);
      REG_Y_SIZE: prdata = PDATA_W'(y_size_q);
      REG_Z_SIZE: prdata = PDATA_W'(z_size_q);
      default:    prdata = '0;
    endcase
  end

  vts_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (req_i),
    .full_o      (full),
    .x_size_i    (x_size_q),
    .y_size_i    (y_size_q),
    .z_size_i    (z_size_q),
    .plane_i     (plane_q),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  vts_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .res_o       (res_o),
    .empty_o     (empty)
  );

endmodule
